@@ hw/rtl/tme_pkg.sv @@
package tme_pkg;

  // Order codes carried in the input tuser field
  typedef enum logic [3:0] {
    OP_MOVE       = 4'd0,
    OP_ADD        = 4'd1,
    OP_LOOP_BEGIN = 4'd2,
    OP_LOOP_END   = 4'd3,
    OP_ZERO       = 4'd4,
    OP_MOVE_CELL  = 4'd5,
    OP_ADD_CELL   = 4'd6,
    OP_PRINT      = 4'd7,
    OP_READ       = 4'd8,
    OP_DUP        = 4'd9,
    OP_NOP        = 4'd10
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_FETCH,
    ST_DATA,
    ST_W1,
    ST_W2
  } seq_state_t;

  // One order as it moves through the front end
  typedef struct packed {
    op_t               op;
    logic signed [15:0] arg;
    logic [7:0]        in_byte;
  } order_t;

  // One result beat
  typedef struct packed {
    logic        jump_taken;
    logic [15:0] jump_target;
    logic [14:0] print_count;
    logic [7:0]  print_byte;
  } result_t;

  // Width of the argument magnitude and number of restoring-reduction steps.
  // The smallest tape is 16 cells, so a 16-bit magnitude has at most 12 quotient bits.
  localparam int MAG_W        = 17;
  localparam int REDUCE_STEPS = 12;

endpackage

@@ hw/rtl/tme_tape_ram.sv @@
module tme_tape_ram
  import tme_pkg::*;
#(
  parameter int TAPE_DEPTH = 32768,
  localparam int AW = $clog2(TAPE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re_a,
  input  logic [AW-1:0] raddr_a,
  output logic [7:0]    rdata_a,
  input  logic          re_b,
  input  logic [AW-1:0] raddr_b,
  output logic [7:0]    rdata_b
);

  logic [7:0] mem [TAPE_DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports, data held when not enabled
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hw/rtl/tme_arg_mod.sv @@
module tme_arg_mod
  import tme_pkg::*;
#(
  parameter int TAPE_DEPTH = 32768,
  localparam int AW = $clog2(TAPE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          hold,
  input  logic          in_valid,
  output logic          in_ready,
  input  order_t        in_ord,
  output logic          ord_valid,
  input  logic          ord_take,
  output order_t        ord,
  output logic [AW-1:0] ord_off
);

  localparam int CW = ((AW > MAG_W) ? AW : MAG_W) + 1;
  localparam int HALF = REDUCE_STEPS / 2;
  localparam logic [47:0] DEP48 = 48'(TAPE_DEPTH);
  localparam logic [CW-1:0] DEP_W = CW'(TAPE_DEPTH);

  logic             v1;
  order_t           ord1;
  logic             neg1;
  logic [MAG_W-1:0] rem1;
  logic             mv1;
  logic             mv2;

  logic [MAG_W-1:0] mag_in;
  logic [MAG_W-1:0] rem1_next;
  logic [MAG_W-1:0] rem2;
  logic [CW-1:0]    off_w;

  // Handshake through the two stages
  assign mv2      = v1 && (!ord_valid || ord_take);
  assign mv1      = in_valid && in_ready;
  assign in_ready = (!v1 || mv2) && !hold;

  // Magnitude of the signed argument
  always_comb begin
    logic [MAG_W-1:0] a_ext;
    a_ext  = {in_ord.arg[15], in_ord.arg};
    mag_in = in_ord.arg[15] ? (~a_ext + MAG_W'(1)) : a_ext;
  end

  // Upper half of the restoring reduction
  always_comb begin
    logic [47:0] sh;
    rem1_next = mag_in;
    for (int k = REDUCE_STEPS - 1; k >= HALF; k--) begin
      sh = DEP48 << k;
      if ({31'd0, rem1_next} >= sh) begin
        rem1_next = rem1_next - sh[MAG_W-1:0];
      end
    end
  end

  // Lower half, then fold the sign into a forward offset
  always_comb begin
    logic [47:0] sh;
    rem2 = rem1;
    for (int k = HALF - 1; k >= 0; k--) begin
      sh = DEP48 << k;
      if ({31'd0, rem2} >= sh) begin
        rem2 = rem2 - sh[MAG_W-1:0];
      end
    end
    if (!neg1) begin
      off_w = CW'(rem2);
    end else if (rem2 == '0) begin
      off_w = '0;
    end else begin
      off_w = DEP_W - CW'(rem2);
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      ord_valid <= 1'b0;
    end else begin
      if (mv1) begin
        v1 <= 1'b1;
      end else if (mv2) begin
        v1 <= 1'b0;
      end
      if (mv2) begin
        ord_valid <= 1'b1;
      end else if (ord_take) begin
        ord_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      ord1 <= in_ord;
      neg1 <= in_ord.arg[15];
      rem1 <= rem1_next;
    end
    if (mv2) begin
      ord     <= ord1;
      ord_off <= off_w[AW-1:0];
    end
  end

endmodule

@@ hw/rtl/tme_seq.sv @@
module tme_seq
  import tme_pkg::*;
#(
  parameter int TAPE_DEPTH = 32768,
  localparam int AW = $clog2(TAPE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  output logic          clearing,
  input  logic          ord_valid,
  output logic          ord_take,
  input  order_t        ord,
  input  logic [AW-1:0] ord_off,
  input  logic          out_free,
  output logic          done,
  output result_t       res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re_a,
  output logic [AW-1:0] mem_raddr_a,
  input  logic [7:0]    mem_rdata_a,
  output logic          mem_re_b,
  output logic [AW-1:0] mem_raddr_b,
  input  logic [7:0]    mem_rdata_b
);

  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(TAPE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPE_DEPTH - 1);

  seq_state_t    state;
  seq_state_t    state_next;
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] ptr;
  logic [AW-1:0] ptr_next;
  order_t        ex;
  logic [7:0]    cur_q;
  logic [7:0]    v1_q;

  logic          start;
  logic          fetch_needs_data;
  logic          ex_neighbor;
  logic [AW-1:0] n1;
  logic [AW-1:0] n2;
  logic [AW-1:0] mov_addr;
  logic          arg_pos;

  // Neighbor and move addresses, wrapped to the tape depth
  always_comb begin
    logic [AW:0] s2;
    logic [AW:0] sm;
    n1 = (ptr == LAST_ADDR) ? '0 : ptr + AW'(1);
    s2 = {1'b0, ptr} + (AW + 1)'(2);
    if (s2 >= DEPTH_W) begin
      s2 = s2 - DEPTH_W;
    end
    n2 = s2[AW-1:0];
    sm = {1'b0, ptr} + {1'b0, ord_off};
    if (sm >= DEPTH_W) begin
      sm = sm - DEPTH_W;
    end
    mov_addr = sm[AW-1:0];
  end

  assign clearing         = (state == ST_CLEAR);
  assign start            = (state == ST_FETCH) && ord_valid && out_free;
  assign ord_take         = start;
  assign fetch_needs_data = ord.op inside {OP_ADD, OP_LOOP_BEGIN, OP_LOOP_END, OP_ZERO,
                                           OP_MOVE_CELL, OP_ADD_CELL, OP_PRINT, OP_READ,
                                           OP_DUP};
  assign ex_neighbor      = ex.op inside {OP_MOVE_CELL, OP_ADD_CELL, OP_DUP};
  assign arg_pos          = !ex.arg[15] && (ex.arg != '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == LAST_ADDR) state_next = ST_FETCH;
      ST_FETCH: if (start && fetch_needs_data) state_next = ST_DATA;
      ST_DATA:  state_next = ex_neighbor ? ST_W1 : ST_FETCH;
      ST_W1:    state_next = (ex.op == OP_DUP) ? ST_W2 : ST_FETCH;
      ST_W2:    state_next = ST_FETCH;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Memory control, result and pointer update
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = ptr;
    mem_wdata   = '0;
    mem_re_a    = 1'b0;
    mem_raddr_a = ptr;
    mem_re_b    = 1'b0;
    mem_raddr_b = n1;
    done        = 1'b0;
    res         = '0;
    ptr_next    = ptr;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      ST_FETCH: begin
        if (start) begin
          mem_re_a = 1'b1;
          mem_re_b = 1'b1;
          if (!fetch_needs_data) begin
            done = 1'b1;
            if (ord.op == OP_MOVE) begin
              ptr_next = mov_addr;
            end
          end
        end
      end
      ST_DATA: begin
        // current cell on port A, next cell on port B; fetch the one after
        mem_re_b    = 1'b1;
        mem_raddr_b = n2;
        done        = !ex_neighbor;
        case (ex.op)
          OP_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata_a + ex.arg[7:0];
          end
          OP_ZERO, OP_MOVE_CELL, OP_ADD_CELL, OP_DUP: begin
            mem_we = 1'b1;
          end
          OP_READ: begin
            mem_we    = arg_pos;
            mem_wdata = ex.in_byte;
          end
          OP_LOOP_BEGIN: begin
            if (mem_rdata_a == '0) begin
              res.jump_taken  = 1'b1;
              res.jump_target = ex.arg;
            end
          end
          OP_LOOP_END: begin
            if (mem_rdata_a != '0) begin
              res.jump_taken  = 1'b1;
              res.jump_target = ex.arg;
            end
          end
          OP_PRINT: begin
            res.print_count = arg_pos ? ex.arg[14:0] : '0;
            res.print_byte  = mem_rdata_a;
          end
          default: begin
          end
        endcase
      end
      ST_W1: begin
        mem_we    = 1'b1;
        mem_waddr = n1;
        mem_wdata = (ex.op == OP_MOVE_CELL) ? cur_q : v1_q + cur_q;
        done      = (ex.op != OP_DUP);
      end
      ST_W2: begin
        // port B still holds the second neighbor
        mem_we    = 1'b1;
        mem_waddr = n2;
        mem_wdata = mem_rdata_b + cur_q;
        done      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      ptr     <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // Order under execution and latched cells
  always_ff @(posedge clk) begin
    if (start) begin
      ex <= ord;
    end
    if (state == ST_DATA) begin
      cur_q <= mem_rdata_a;
      v1_q  <= mem_rdata_b;
    end
  end

endmodule

@@ hw/rtl/tape_machine_execute_unit.sv @@
// Tape machine execute unit.
// Input channel s_*: one compiled order per beat; s_tuser carries the order
// code, s_tdata the signed argument and the input byte. Output channel m_*:
// exactly one result beat per order (jump flag and target, print count and
// byte), in order.
// Throughput is set by the tape memory's single write port and the
// sequencer: move and no-op need only the fetch state; add, zero, loop,
// print and read also pass the data state; move cell and add cell add
// a neighbor write state, and duplicate a second one.
// A two-stage front end reduces the move argument modulo the tape depth and
// keeps taking beats while an order executes or a result waits.
// After reset the tape is cleared one cell per cycle; s_tready stays low
// until the clear is done, and the data pointer resets to zero.
// When the receiver stalls, the result is held in the output register and
// no new order starts; up to two further orders are buffered in front.
module tape_machine_execute_unit
  import tme_pkg::*;
#(
  parameter int TAPE_DEPTH = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // argument[15:0], in_byte[23:16]
  input  logic [3:0]  s_tuser,   // req_type[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // jump_taken[0], jump_target[16:1],
                                 // print_count[31:17], print_byte[39:32]
);

  localparam int AW = $clog2(TAPE_DEPTH);

  order_t        in_ord;
  order_t        ord;
  logic          ord_valid;
  logic          ord_take;
  logic [AW-1:0] ord_off;
  logic          clearing;
  logic          out_free;
  logic          done;
  result_t       res;
  result_t       out_res;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re_a;
  logic [AW-1:0] mem_raddr_a;
  logic [7:0]    mem_rdata_a;
  logic          mem_re_b;
  logic [AW-1:0] mem_raddr_b;
  logic [7:0]    mem_rdata_b;

  // Unpack the input beat
  assign in_ord.op      = op_t'(s_tuser);
  assign in_ord.arg     = s_tdata[15:0];
  assign in_ord.in_byte = s_tdata[23:16];

  tme_arg_mod #(
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_arg_mod (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_ord    (in_ord),
    .ord_valid (ord_valid),
    .ord_take  (ord_take),
    .ord       (ord),
    .ord_off   (ord_off)
  );

  tme_seq #(
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .clearing    (clearing),
    .ord_valid   (ord_valid),
    .ord_take    (ord_take),
    .ord         (ord),
    .ord_off     (ord_off),
    .out_free    (out_free),
    .done        (done),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re_a    (mem_re_a),
    .mem_raddr_a (mem_raddr_a),
    .mem_rdata_a (mem_rdata_a),
    .mem_re_b    (mem_re_b),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_b (mem_rdata_b)
  );

  tme_tape_ram #(
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re_a    (mem_re_a),
    .raddr_a (mem_raddr_a),
    .rdata_a (mem_rdata_a),
    .re_b    (mem_re_b),
    .raddr_b (mem_raddr_b),
    .rdata_b (mem_rdata_b)
  );

  // Output register; an order starts only when this slot frees up
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.print_byte, out_res.print_count,
                    out_res.jump_target, out_res.jump_taken};

endmodule

@@ test/tape_machine_execute_unit_test.sv @@
module tape_machine_execute_unit_test;
  import tme_pkg::*;

  localparam int TAPE_CELLS  = 32768;
  // longest output hold-off, in cycles
  localparam int HOLD_CYCLES = 200;
  // cycles with no beat on either side before giving up; the tape clear
  // after reset also counts toward this limit
  localparam int STALL_LIMIT = 100000;
  localparam int RAND_PER_PHASE = 225;

  // codes above the no-op are undefined and must behave as no-ops
  localparam logic [3:0] CODE_UNDEF_FIRST = 4'd11;
  localparam logic [3:0] CODE_UNDEF_LAST  = 4'd15;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_TX_IDLE,
    PH_RX_STALL,
    PH_BOTH
  } phase_t;

  typedef struct {
    logic [3:0]  code;
    logic [15:0] arg;
    logic [7:0]  in_byte;
    phase_t      phase;
    bit          hold;   // start a long output hold-off with this order
    bit          drain;  // wait for every result before sending this order
  } order_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // argument[15:0], in_byte[23:16]
  logic [3:0]  s_tuser = '0;   // req_type[3:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // jump_taken[0], jump_target[16:1],
                               // print_count[31:17], print_byte[39:32]

  order_beat_t order_q[$];
  result_t     result_q[$];

  // predictor state
  logic [7:0]  tape_mem [TAPE_CELLS];
  logic [14:0] data_ptr = '0;

  phase_t cur_phase = PH_STEADY;
  logic   hold_start = 1'b0;
  int     hold_cnt = 0;
  int     stall_cycles = 0;
  int     err_count = 0;
  int     n_orders = 0;
  int     n_results = 0;
  int     n_jumps = 0;
  int     n_prints = 0;

  tape_machine_execute_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Executes one order on the shadow tape and returns its result
  function automatic result_t exec_order(logic [3:0] code, logic [15:0] arg,
                                         logic [7:0] in_byte);
    result_t     r;
    logic [14:0] p;
    logic [14:0] n1;
    logic [14:0] n2;
    logic [7:0]  cur;
    logic        positive;
    r        = '0;
    p        = data_ptr;
    n1       = p + 15'd1;
    n2       = p + 15'd2;
    cur      = tape_mem[p];
    positive = !arg[15] && (arg != 16'd0);
    case (code)
      OP_MOVE: begin
        // depth is a power of two, so the low bits give the wrapped move
        data_ptr = p + arg[14:0];
      end
      OP_ADD: tape_mem[p] = cur + arg[7:0];
      OP_LOOP_BEGIN: begin
        if (cur == 8'd0) begin
          r.jump_taken  = 1'b1;
          r.jump_target = arg;
        end
      end
      OP_LOOP_END: begin
        if (cur != 8'd0) begin
          r.jump_taken  = 1'b1;
          r.jump_target = arg;
        end
      end
      OP_ZERO: tape_mem[p] = 8'd0;
      OP_MOVE_CELL: begin
        tape_mem[n1] = cur;
        tape_mem[p]  = 8'd0;
      end
      OP_ADD_CELL: begin
        tape_mem[n1] = tape_mem[n1] + cur;
        tape_mem[p]  = 8'd0;
      end
      OP_PRINT: begin
        r.print_count = positive ? arg[14:0] : 15'd0;
        r.print_byte  = cur;
      end
      OP_READ: begin
        if (positive) tape_mem[p] = in_byte;
      end
      OP_DUP: begin
        tape_mem[n1] = tape_mem[n1] + cur;
        tape_mem[n2] = tape_mem[n2] + cur;
        tape_mem[p]  = 8'd0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int tx_idle_pct(phase_t ph);
    case (ph)
      PH_TX_IDLE: return 52;
      PH_BOTH:    return 21;
      default:    return 0;
    endcase
  endfunction

  function automatic int rx_stall_pct(phase_t ph);
    case (ph)
      PH_RX_STALL: return 52;
      PH_BOTH:     return 21;
      default:     return 0;
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic push_order(input logic [3:0] code, input logic [15:0] arg,
                            input logic [7:0] in_byte);
    order_beat_t b;
    b = '{code: code, arg: arg, in_byte: in_byte, phase: PH_STEADY,
          hold: 1'b0, drain: 1'b0};
    order_q.push_back(b);
  endtask

  // Random order, weighted so the pointer stays near a few cells that
  // build up nonzero values and loops see both outcomes
  function automatic order_beat_t rand_order(phase_t ph);
    order_beat_t b;
    int          k;
    k         = $urandom_range(0, 99);
    b.arg     = 16'($urandom);
    b.in_byte = 8'($urandom);
    b.phase   = ph;
    b.hold    = 1'b0;
    b.drain   = 1'b0;
    if (k < 25) begin
      b.code = OP_MOVE;
      if ($urandom_range(0, 19) != 0) b.arg = 16'($urandom_range(0, 6)) - 16'd3;
    end else if (k < 45) b.code = OP_ADD;
    else if (k < 53) b.code = OP_LOOP_BEGIN;
    else if (k < 60) b.code = OP_LOOP_END;
    else if (k < 64) b.code = OP_ZERO;
    else if (k < 69) b.code = OP_MOVE_CELL;
    else if (k < 74) b.code = OP_ADD_CELL;
    else if (k < 79) b.code = OP_DUP;
    else if (k < 89) begin
      b.code = OP_PRINT;
      if ($urandom_range(0, 1) != 0) b.arg = 16'($urandom_range(0, 8)) - 16'd2;
    end else if (k < 97) b.code = OP_READ;
    else if (k < 99) b.code = OP_NOP;
    else b.code = 4'($urandom_range(CODE_UNDEF_FIRST, CODE_UNDEF_LAST));
    return b;
  endfunction

  // Driver: offers queued orders, predicts each accepted beat
  always @(posedge clk) begin : drive
    logic        nxt_valid;
    logic        nxt_hold;
    order_beat_t head;
    if (rst) begin
      s_tvalid   <= 1'b0;
      hold_start <= 1'b0;
    end else begin
      nxt_valid = s_tvalid;
      nxt_hold  = 1'b0;
      if (s_tvalid && s_tready) begin
        result_q.push_back(exec_order(s_tuser, s_tdata[15:0], s_tdata[23:16]));
        n_orders++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && order_q.size() != 0) begin
        head = order_q[0];
        if (!(head.drain && result_q.size() != 0) &&
            $urandom_range(0, 99) >= tx_idle_pct(head.phase)) begin
          s_tdata   <= {head.in_byte, head.arg};
          s_tuser   <= head.code;
          cur_phase <= head.phase;
          nxt_valid = 1'b1;
          nxt_hold  = head.hold;
          void'(order_q.pop_front());
        end
      end
      s_tvalid   <= nxt_valid;
      hold_start <= nxt_hold;
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold_cnt <= 0;
    else if (hold_start) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // Monitor: checks each result beat against the oldest prediction
  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.jump_taken  = m_tdata[0];
        got.jump_target = m_tdata[16:1];
        got.print_count = m_tdata[31:17];
        got.print_byte  = m_tdata[39:32];
        n_results++;
        if (result_q.size() == 0) begin
          report_error($sformatf("result beat %h with nothing expected", m_tdata));
        end else begin
          want = result_q.pop_front();
          if (want.jump_taken) n_jumps++;
          if (want.print_count != 15'd0) n_prints++;
          if (got.jump_taken != want.jump_taken)
            report_error($sformatf("result %0d jump_taken %0d, expected %0d",
                                   n_results, got.jump_taken, want.jump_taken));
          if (got.jump_target != want.jump_target)
            report_error($sformatf("result %0d jump_target %h, expected %h",
                                   n_results, got.jump_target, want.jump_target));
          if (got.print_count != want.print_count)
            report_error($sformatf("result %0d print_count %h, expected %h",
                                   n_results, got.print_count, want.print_count));
          if (got.print_byte != want.print_byte)
            report_error($sformatf("result %0d print_byte %h, expected %h",
                                   n_results, got.print_byte, want.print_byte));
        end
      end
      m_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rx_stall_pct(cur_phase));
    end
  end

  // Cycles without any beat
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout after %0d idle cycles", STALL_LIMIT);
    $display("tape_machine_execute_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    order_beat_t b;
    phase_t      ph;
    for (int i = 0; i < TAPE_CELLS; i++) tape_mem[i] = 8'd0;

    // directed: loop outcomes on a zero cell, odd counts, wraps
    push_order(OP_LOOP_BEGIN, 16'h1234, 8'h00);
    push_order(OP_LOOP_END,   16'h0042, 8'h00);
    push_order(OP_PRINT,      16'hFFFF, 8'hFF);   // negative count
    push_order(OP_READ,       16'h0000, 8'hAA);   // zero count, no store
    push_order(OP_READ,       16'hFFFB, 8'h55);   // negative count, no store
    push_order(OP_ADD,        16'h7FFF, 8'h00);
    push_order(OP_PRINT,      16'h7FFF, 8'h00);   // largest count
    push_order(OP_PRINT,      16'h0000, 8'h00);   // zero count, byte shown
    push_order(OP_LOOP_END,   16'hFFFF, 8'hFF);
    push_order(OP_LOOP_BEGIN, 16'h8000, 8'h00);
    push_order(OP_ADD,        16'h8000, 8'h00);
    push_order(OP_ADD,        16'h0001, 8'h00);   // cell wraps to zero
    push_order(OP_READ,       16'h0001, 8'hFF);
    push_order(OP_MOVE_CELL,  16'h0000, 8'h00);
    push_order(OP_MOVE,       16'h0001, 8'h00);
    push_order(OP_ADD_CELL,   16'h0000, 8'h00);
    push_order(OP_MOVE,       16'h8000, 8'h00);   // full-depth move
    push_order(OP_MOVE,       16'hFFFD, 8'h00);   // pointer wraps below zero
    push_order(OP_READ,       16'h0003, 8'h80);
    push_order(OP_DUP,        16'h0000, 8'h00);   // neighbors wrap past the top
    push_order(OP_MOVE,       16'h7FFF, 8'h00);
    push_order(OP_ZERO,       16'h0000, 8'h00);
    push_order(OP_NOP,        16'hFFFF, 8'hFF);
    push_order(CODE_UNDEF_LAST, 16'hFFFF, 8'hFF);
    push_order(OP_PRINT,      16'h0005, 8'h00);

    // random phases, each with its own idling pattern
    for (int p = 0; p < 4; p++) begin
      ph = phase_t'(p);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        b = rand_order(ph);
        if (i == 0 && ph == PH_STEADY) b.hold = 1'b1;
        if (i == 0 && (ph == PH_TX_IDLE || ph == PH_BOTH)) b.drain = 1'b1;
        order_q.push_back(b);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (order_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d orders sent, %0d results checked (%0d jumps, %0d prints)",
             n_orders, n_results, n_jumps, n_prints);
    $display("phases: steady with long output hold-off, sender gaps, receiver stalls, both");
    if (err_count == 0) begin
      $display("tape_machine_execute_unit: match");
    end else begin
      $display("tape_machine_execute_unit: mismatch");
    end
    $finish;
  end

endmodule
